@@ design/bth_pkg.sv @@
// ----------------------------------------------------------------------------
// bth_pkg: shared constants and types for the Booth radix-2 multiplier
// Operand, accumulator and product widths, plus the control word that the
// sequencer broadcasts to the row of bit cells.
// ----------------------------------------------------------------------------
package bth_pkg;

    localparam int WIDTH = 16;
    localparam int A_W   = WIDTH + 1;        // accumulator, one guard bit
    localparam int P_W   = 2 * WIDTH;
    localparam int CNT_W = $clog2(WIDTH);

    // Control word broadcast to every bit cell
    typedef struct packed {
        logic load;    // capture multiplicand bit, clear accumulator bit
        logic step;    // take the shifted-in sum bit
        logic add_en;  // Booth pair 01 or 10: add or subtract this step
        logic sub;     // Booth pair 10: subtract (invert M, carry in one)
    } t_cell_ctl;

endpackage

@@ design/bth_cell.sv @@
// ----------------------------------------------------------------------------
// bth_cell: one bit slice of the Booth accumulator
// Holds one multiplicand bit and one accumulator bit. Forms one sum bit of
// A +/- M on the ripple carry and takes the sum bit of its left neighbor on
// each step, which is the arithmetic right shift of A.
// ----------------------------------------------------------------------------
module bth_cell (
    input  logic               i_clk,
    input  bth_pkg::t_cell_ctl i_ctl,
    input  logic               i_m_bit,
    input  logic               i_carry,
    input  logic               i_shift_in,
    output logic               o_carry,
    output logic               o_sum,
    output logic               o_a_bit
);
    import bth_pkg::*;

    logic r_m;
    logic r_a;
    logic w_b;

    assign w_b     = i_ctl.add_en & (r_m ^ i_ctl.sub);
    assign o_sum   = r_a ^ w_b ^ i_carry;
    assign o_carry = (r_a & w_b) | (r_a & i_carry) | (w_b & i_carry);
    assign o_a_bit = r_a;

    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_m <= i_m_bit;
            r_a <= 1'b0;
        end else if (i_ctl.step) begin
            r_a <= i_shift_in;
        end
    end

endmodule

@@ design/booth_radix2_multiplier.sv @@
// ----------------------------------------------------------------------------
// booth_radix2_multiplier: signed radix-2 Booth multiplier, bit-slice array
// Multiplies two signed 16-bit operands into a signed 32-bit product.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel: i_in_valid / o_in_stall carry i_multiplicand and
//   i_multiplier. Output channel: o_out_valid / i_out_stall carry o_product.
//   A transfer happens on a clock edge with valid high and stall low.
//   The transfer edge loads the operands into the cell row, then WIDTH
//   steps follow, one Booth add/subtract and shift per cycle through the
//   ripple carry of the WIDTH+1 cells. The product lands in the output
//   register on the last step edge when the output register is free.
//   The single shared add/shift row takes no new item until the last one
//   has left it. o_in_stall is high while an item is in the row.
//   The output register frees the row: a new item is taken while a product
//   waits. If the receiver still stalls the previous product when a new one
//   finishes, the row holds its result and o_in_stall stays high until the
//   output register frees up.
//   Reset (i_rst_n low, synchronous) returns the sequencer to idle and
//   empties the output register; no clearing pass is needed.
// ----------------------------------------------------------------------------
module booth_radix2_multiplier (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_in_valid,
    output logic                             o_in_stall,
    input  logic signed [bth_pkg::WIDTH-1:0] i_multiplicand,
    input  logic signed [bth_pkg::WIDTH-1:0] i_multiplier,
    output logic                             o_out_valid,
    input  logic                             i_out_stall,
    output logic signed [bth_pkg::P_W-1:0]   o_product
);
    import bth_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_RUN,
        S_HOLD
    } t_state;

    t_state              r_state;
    logic [WIDTH-1:0]    r_q;
    logic                r_qx;
    logic [CNT_W-1:0]    r_cnt;
    logic                r_out_valid;
    logic [P_W-1:0]      r_product;

    t_cell_ctl           w_ctl;
    logic [A_W:0]        w_carry;
    logic [A_W-1:0]      w_sum;
    logic [A_W-1:0]      w_a;
    logic [A_W-1:0]      w_shift_in;
    logic [A_W-1:0]      w_m_ext;
    logic                w_in_xfer;
    logic                w_out_free;
    logic                w_last;
    logic                w_prod_load;

    assign w_in_xfer  = i_in_valid & (r_state == S_IDLE);
    assign w_out_free = ~r_out_valid | ~i_out_stall;
    assign w_last     = (r_cnt == CNT_W'(WIDTH - 1));
    // output register takes a new product this edge
    assign w_prod_load = w_out_free &
                         (((r_state == S_RUN) & w_last) | (r_state == S_HOLD));

    assign w_ctl.load   = w_in_xfer;
    assign w_ctl.step   = (r_state == S_RUN);
    assign w_ctl.add_en = r_q[0] ^ r_qx;
    assign w_ctl.sub    = r_q[0] & ~r_qx;

    assign w_m_ext    = {i_multiplicand[WIDTH-1], i_multiplicand};
    assign w_carry[0] = w_ctl.sub;
    // arithmetic shift: each cell takes its left neighbor's sum, top keeps sign
    assign w_shift_in = {w_sum[A_W-1], w_sum[A_W-1:1]};

    for (genvar g = 0; g < A_W; g++) begin : g_cell
        bth_cell u_cell (
            .i_clk      (i_clk),
            .i_ctl      (w_ctl),
            .i_m_bit    (w_m_ext[g]),
            .i_carry    (w_carry[g]),
            .i_shift_in (w_shift_in[g]),
            .o_carry    (w_carry[g+1]),
            .o_sum      (w_sum[g]),
            .o_a_bit    (w_a[g])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_cnt       <= '0;
        end else begin
            if (r_out_valid && !i_out_stall && !w_prod_load) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (w_in_xfer) begin
                        r_q     <= i_multiplier;
                        r_qx    <= 1'b0;
                        r_cnt   <= '0;
                        r_state <= S_RUN;
                    end
                end
                S_RUN: begin
                    r_q   <= {w_sum[0], r_q[WIDTH-1:1]};
                    r_qx  <= r_q[0];
                    r_cnt <= r_cnt + CNT_W'(1);
                    if (w_last) begin
                        if (w_out_free) begin
                            // product straight from this step's shifted values
                            r_product   <= {w_sum[WIDTH:0], r_q[WIDTH-1:1]};
                            r_out_valid <= 1'b1;
                            r_state     <= S_IDLE;
                        end else begin
                            r_state <= S_HOLD;
                        end
                    end
                end
                S_HOLD: begin
                    if (w_out_free) begin
                        r_product   <= {w_a[WIDTH-1:0], r_q};
                        r_out_valid <= 1'b1;
                        r_state     <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_product   = r_product;

endmodule

@@ design/bth_checker.sv @@
// ----------------------------------------------------------------------------
// bth_checker: port-level checks for the Booth multiplier
// Watches the channel handshakes and the occupancy of the cell row.
// ----------------------------------------------------------------------------
module bth_checker (
    input logic                           i_clk,
    input logic                           i_rst_n,
    input logic                           i_in_valid,
    input logic                           o_in_stall,
    input logic                           o_out_valid,
    input logic                           i_out_stall,
    input logic [bth_pkg::P_W-1:0]        o_product
);
    import bth_pkg::*;

    // held product must not drop or change while stalled
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_product))
        else $error("stalled product dropped or changed");

    // row is busy after a transfer and is still busy on its last step
    a_busy_after_xfer: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> o_in_stall)
        else $error("input taken again right after a transfer");

    a_busy_all_steps: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |-> ##WIDTH o_in_stall)
        else $error("row freed before all steps done");

    // reset empties the output register and idles the row
    a_reset_clear: assert property (@(posedge i_clk)
        !$past(i_rst_n) |-> !o_out_valid && !o_in_stall)
        else $error("reset did not clear the block");

endmodule

bind booth_radix2_multiplier bth_checker u_bth_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_stall  (o_in_stall),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_product   (o_product)
);

@@ bench/booth_radix2_multiplier_tb.sv @@
// ----------------------------------------------------------------------------
// booth_radix2_multiplier_tb: self-checking bench for the Booth multiplier
// Drives a short table of corner operand pairs and then random pairs through
// the valid/stall input channel, with bursty input traffic and a patterned
// output stall. Every product is checked against a typed-in value or a bit-level Booth predictor.
// ----------------------------------------------------------------------------
module booth_radix2_multiplier_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import bth_pkg::*;

    localparam int RANDOM_ITEMS = 1750;
    localparam int LONG_HOLD    = 300;
    localparam int SETTLE       = WIDTH + 4;

    typedef struct packed {
        logic signed [WIDTH-1:0] mcand;
        logic signed [WIDTH-1:0] mplier;
        logic signed [P_W-1:0]   product;
        logic                    known;    // product typed in, else predicted
    } t_mult_case;

    typedef enum int {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_PERIODIC} t_stall_mode;

    localparam t_mult_case DIRECTED[21] = '{
        '{16'sh0000, 16'sh0000, 32'sh00000000, 1'b1},
        '{16'sh8000, 16'sh8000, 32'sh40000000, 1'b1},  // most negative squared
        '{16'sh8000, 16'sh7FFF, 32'shC0008000, 1'b1},
        '{16'sh7FFF, 16'sh8000, 32'shC0008000, 1'b1},
        '{16'sh7FFF, 16'sh7FFF, 32'sh3FFF0001, 1'b1},
        '{16'shFFFF, 16'shFFFF, 32'sh00000001, 1'b1},
        '{16'sh0001, 16'shFFFF, 32'shFFFFFFFF, 1'b1},
        '{16'shFFFF, 16'sh0001, 32'shFFFFFFFF, 1'b1},
        '{16'sh8000, 16'sh0001, 32'shFFFF8000, 1'b1},
        '{16'sh0001, 16'sh8000, 32'shFFFF8000, 1'b1},
        '{16'sh8000, 16'shFFFF, 32'sh00008000, 1'b1},
        '{16'shFFFF, 16'sh8000, 32'sh00008000, 1'b1},
        '{16'sh8000, 16'sh0000, 32'sh00000000, 1'b1},
        '{16'sh0000, 16'sh8000, 32'sh00000000, 1'b1},
        '{16'sh7FFF, 16'shFFFF, 32'shFFFF8001, 1'b1},
        '{16'sh0002, 16'sh7FFF, 32'sh0000FFFE, 1'b1},
        '{16'sh5555, 16'shAAAA, 32'sh00000000, 1'b0},  // recode pair flips every step
        '{16'shAAAA, 16'sh5555, 32'sh00000000, 1'b0},
        '{16'sh1234, 16'sh5678, 32'sh00000000, 1'b0},
        '{16'shEDCC, 16'sh0FF0, 32'sh00000000, 1'b0},
        '{16'sh0F0F, 16'shF0F0, 32'sh00000000, 1'b0}
    };

    logic                    i_clk = 1'b0;
    logic                    i_rst_n = 1'b0;
    logic                    i_in_valid = 1'b0;
    logic                    o_in_stall;
    logic signed [WIDTH-1:0] i_multiplicand = '0;
    logic signed [WIDTH-1:0] i_multiplier = '0;
    logic                    o_out_valid;
    logic                    i_out_stall = 1'b0;
    logic signed [P_W-1:0]   o_product;

    logic signed [P_W-1:0]   offer_product = '0;   // expected product of the offered pair
    logic signed [P_W-1:0]   product_q[$];
    int                      mismatch_count = 0;
    int                      items_sent = 0;
    int                      products_checked = 0;
    bit                      hold_request = 1'b0;
    bit                      hold_done = 1'b0;

    booth_radix2_multiplier u_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_multiplicand (i_multiplicand),
        .i_multiplier   (i_multiplier),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_product      (o_product)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // Radix-2 Booth recoding over A:Q:Q-1, A one bit wider than the operands
    function automatic logic signed [P_W-1:0] booth_product(
        input logic signed [WIDTH-1:0] mcand,
        input logic signed [WIDTH-1:0] mplier
    );
        logic [A_W-1:0]   acc;
        logic [A_W-1:0]   mext;
        logic [WIDTH-1:0] qreg;
        logic             qm1;
        acc  = '0;
        mext = {mcand[WIDTH-1], mcand};
        qreg = mplier;
        qm1  = 1'b0;
        for (int s = 0; s < WIDTH; s++) begin
            case ({qreg[0], qm1})
                2'b01:   acc = acc + mext;
                2'b10:   acc = acc - mext;
                default: ;
            endcase
            {acc, qreg, qm1} = {acc[A_W-1], acc, qreg};
        end
        return {acc[WIDTH-1:0], qreg};
    endfunction

    function automatic logic signed [WIDTH-1:0] rand_operand();
        logic [WIDTH-1:0] v;
        case ($urandom_range(0, 9))
            0: begin
                case ($urandom_range(0, 4))
                    0:       v = '0;
                    1:       v = WIDTH'(1);
                    2:       v = '1;
                    3:       v = {1'b0, {(WIDTH-1){1'b1}}};
                    default: v = {1'b1, {(WIDTH-1){1'b0}}};
                endcase
            end
            1:       v = WIDTH'($urandom_range(0, 16)) - WIDTH'(8);
            2:       v = WIDTH'(1) << $urandom_range(0, WIDTH - 1);
            3:       v = $urandom_range(0, 1) ? 16'h5555 : 16'hAAAA;
            default: v = WIDTH'($urandom);
        endcase
        return v;
    endfunction

    task automatic offer(
        input logic signed [WIDTH-1:0] mcand,
        input logic signed [WIDTH-1:0] mplier,
        input logic signed [P_W-1:0]   product
    );
        i_in_valid     <= 1'b1;
        i_multiplicand <= mcand;
        i_multiplier   <= mplier;
        offer_product  <= product;
        do @(posedge i_clk); while (o_in_stall);
        items_sent++;
    endtask

    // always waits on the clock before it returns, so valid is never lowered and raised in one step
    task automatic drain();
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (product_q.size() != 0);
    endtask

    task automatic report_mismatch(
        input string                 what,
        input logic signed [P_W-1:0] want,
        input logic signed [P_W-1:0] got
    );
        mismatch_count++;
        if (mismatch_count <= 10) begin
            $display("%0t ns: %s: expected %0d (0x%h), got %0d (0x%h)",
                     $realtime, what, want, want, got, got);
        end
    endtask

    always @(posedge i_clk) begin : scoreboard
        logic signed [P_W-1:0] want;
        if (i_rst_n) begin
            if (i_in_valid && !o_in_stall)
                product_q.push_back(offer_product);
            if (o_out_valid && !i_out_stall) begin
                if (product_q.size() == 0) begin
                    report_mismatch("product with no pending transfer", 'x, o_product);
                end else begin
                    want = product_q.pop_front();
                    products_checked++;
                    if (o_product !== want)
                        report_mismatch("product mismatch", want, o_product);
                end
            end
        end
    end

    initial begin : out_stall_gen
        int          seg_left;
        int          period;
        int          hold_left;
        t_stall_mode mode;
        seg_left  = 0;
        period    = 2;
        hold_left = 0;
        mode      = STALL_NONE;
        forever begin
            @(posedge i_clk);
            if (hold_request && !hold_done) begin
                hold_left = LONG_HOLD;
                hold_done = 1'b1;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_out_stall <= 1'b1;
            end else begin
                if (seg_left == 0) begin
                    mode     = t_stall_mode'($urandom_range(0, 3));
                    period   = $urandom_range(2, 23);
                    seg_left = $urandom_range(40, 400);
                end
                seg_left--;
                case (mode)
                    STALL_NONE:  i_out_stall <= 1'b0;
                    STALL_LIGHT: i_out_stall <= ($urandom_range(0, 3) == 0);
                    STALL_HEAVY: i_out_stall <= ($urandom_range(0, 3) != 0);
                    default:     i_out_stall <= ((seg_left % period) < (period / 2));
                endcase
            end
        end
    end

    initial begin : stimulus
        int                      gap;
        int                      burst_left;
        logic signed [WIDTH-1:0] a;
        logic signed [WIDTH-1:0] b;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (DIRECTED[k]) begin
            offer(DIRECTED[k].mcand, DIRECTED[k].mplier,
                  DIRECTED[k].known ? DIRECTED[k].product
                                    : booth_product(DIRECTED[k].mcand, DIRECTED[k].mplier));
        end
        drain();

        // back-to-back burst while the receiver holds off: row and output fill up
        hold_request = 1'b1;
        burst_left   = 40;
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            if (n == RANDOM_ITEMS / 2) begin
                drain();
                burst_left = $urandom_range(1, 30);
            end else if (burst_left == 0) begin
                gap = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
                                                  : $urandom_range(1, 18);
                i_in_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
                burst_left = $urandom_range(1, 30);
            end
            a = rand_operand();
            b = rand_operand();
            offer(a, b, booth_product(a, b));
            burst_left--;
        end
        drain();
        repeat (SETTLE) @(posedge i_clk);

        $display("Run covered %0d operand pairs (%0d from the corner table), %0d products checked,",
                 items_sent, $size(DIRECTED), products_checked);
        $display("with bursty input, patterned output stall and a %0d-cycle output hold.",
                 LONG_HOLD);
        if (mismatch_count == 0 && product_q.size() == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("%0d mismatches, %0d products still pending", mismatch_count,
                     product_q.size());
            $display("CHECKS FAILED");
        end
        $finish;
    end

    initial begin : watchdog
        #2_000_000;
        $display("Timeout: %0d pairs sent, %0d products checked", items_sent, products_checked);
        $display("CHECKS FAILED");
        $finish;
    end

endmodule
